@@ src/spmp_pkg.sv @@
// Shared types and constants of the multichannel spread panner.
`default_nettype none

package spmp_pkg;

  // Field widths
  localparam int DATA_W   = 16;   // sample, gain, azimuth, spread, level
  localparam int CNT_W    = 5;    // channel count register
  localparam int CHAN_W   = 4;    // channel field on the output
  localparam int FRAC_W   = 12;   // fraction bits of a channel position
  localparam int X_W      = CNT_W + FRAC_W;       // position within the circle
  localparam int POS_W    = X_W + 1;              // unwrapped position
  localparam int AMP_W    = 15;   // sine magnitude, Q1.15 without sign
  localparam int PROD1_W  = 2 * DATA_W;           // sample * amplitude
  localparam int PROD2_W  = PROD1_W + DATA_W;     // ... * gain
  localparam int ROUND_SHIFT = 29;
  localparam int SCALED_W = PROD2_W - ROUND_SHIFT;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  localparam logic [CNT_W-1:0]  MIN_CHANNELS = CNT_W'(2);
  localparam logic [CNT_W-1:0]  RESET_CHANNELS = CNT_W'(2);
  localparam logic [DATA_W-1:0] SPREAD_MIN = DATA_W'(410);   // 0.1 channel in Q4.12
  localparam logic [X_W-1:0]    X_ONE = X_W'(1 << FRAC_W);   // one channel step

  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;

  localparam logic signed [SCALED_W-1:0] LEVEL_MAX = SCALED_W'(32767);
  localparam logic signed [SCALED_W-1:0] LEVEL_MIN = -SCALED_W'(32768);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_COUNT = 2'd0,
    REG_OFFSET_TURNS  = 2'd1
  } cfg_reg_t;

  // One classified input item, handed from the front to the back
  typedef struct packed {
    logic [CNT_W-1:0]         n;       // effective channel count
    logic [X_W-1:0]           x0;      // position of channel 0, wrapped, Q.12
    logic [X_W-1:0]           two_s;   // twice the clamped spread, Q.12
    logic signed [DATA_W-1:0] sample;
    logic signed [DATA_W-1:0] gain;
  } item_t;

endpackage

`default_nettype wire

@@ src/multichannel_spread_panner.sv @@
// Top level of the multichannel spread panner: config registers, front, queue, back.
//
//  channel | dir | fields (lowest bit first)                      | accepted when
//  s_axis  | in  | tdata: sample, gain, azimuth, spread (16 each)  | tvalid & tready
//  m_axis  | out | tdata: channel[3:0], level[19:4]; tlast: last  | tvalid & tready
//  cfg     | in  | cfg_index 0 channel_count, 1 offset_turns       | cfg_we
//
// Each input transaction yields N output transactions (N = clamped channel_count),
// one per cycle while m_axis is not stalled, from the back-end channel sequencer.
// The front takes one item per cycle, while the queue has room, into a 4-entry
// queue, and the back pipeline runs sequencer, divider stages, sine read and scaling.
// After rst the sine table RAM is loaded, 2^(SINE_TABLE_BITS-1)+1 entries
// (513 by default), with s_axis_tready low; config writes are taken meanwhile.
// An m_axis stall freezes the back pipeline only; the front keeps filling the queue.
`default_nettype none

module multichannel_spread_panner import spmp_pkg::*; #(
  parameter int MAX_CHANNELS    = 16,
  parameter int SINE_TABLE_BITS = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // slave stream
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [63:0]          s_axis_tdata,   // sample, gain, azimuth, spread
  // master stream
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [23:0]               m_axis_tdata,   // channel, level, zero pad
  output logic                      m_axis_tlast,
  // configuration writes
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_data
);

  // ---------------- configuration ----------------
  logic [CNT_W-1:0]  channel_count;
  logic [DATA_W-1:0] offset_turns;
  logic [CNT_W-1:0]  n_eff;
  logic [CNT_W-1:0]  n_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= RESET_CHANNELS;
      offset_turns  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CHANNEL_COUNT: channel_count <= cfg_data[CNT_W-1:0];
        REG_OFFSET_TURNS:  offset_turns  <= cfg_data;
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // speaker count clamped to the supported range
  always_comb begin
    if (channel_count < MIN_CHANNELS) begin
      n_eff = MIN_CHANNELS;
    end else if (32'(channel_count) > MAX_CHANNELS) begin
      n_eff = CNT_W'(MAX_CHANNELS);
    end else begin
      n_eff = channel_count;
    end
  end

  assign n_last = n_eff - 1'b1;

  // ---------------- front / queue / back ----------------
  logic   fill_busy;
  logic   q_push;
  logic   q_full;
  logic   q_pop;
  logic   q_valid;
  item_t  q_in;
  item_t  q_out;
  logic [CHAN_W-1:0]        out_channel;
  logic signed [DATA_W-1:0] out_level;

  spmp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .hold         (fill_busy),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_sample    (s_axis_tdata[15:0]),
    .in_gain      (s_axis_tdata[31:16]),
    .in_azimuth   (s_axis_tdata[47:32]),
    .in_spread    (s_axis_tdata[63:48]),
    .n_eff        (n_eff),
    .offset_turns (offset_turns),
    .push         (q_push),
    .push_item    (q_in),
    .full         (q_full)
  );

  spmp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_out),
    .valid     (q_valid)
  );

  spmp_back #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_out),
    .q_pop       (q_pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_channel (out_channel),
    .out_level   (out_level),
    .out_last    (m_axis_tlast),
    .fill_busy   (fill_busy)
  );

  assign m_axis_tdata = {4'b0000, out_level, out_channel};

  // ---------------- checks ----------------
`ifndef SYNTHESIS
  // no item may enter before the sine table is loaded
  a_no_accept_during_fill: assert property (@(posedge clk) disable iff (rst)
    fill_busy |-> !s_axis_tready)
    else $error("input taken while sine table loads");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("queue overflow");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue underflow");

  // tlast marks the highest channel of the current count
  a_last_channel: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[3:0] == n_last[CHAN_W-1:0])
    else $error("tlast on wrong channel");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");
`endif

endmodule

`default_nettype wire

@@ src/spmp_ram.sv @@
// Generic single-port-write, registered-read RAM.
`default_nettype none

module spmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ src/spmp_front.sv @@
// Front end: takes input transactions and works out each item's circle position.
`default_nettype none

module spmp_front import spmp_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     hold,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [DATA_W-1:0] in_sample,
  input  wire logic signed [DATA_W-1:0] in_gain,
  input  wire logic [DATA_W-1:0]        in_azimuth,
  input  wire logic [DATA_W-1:0]        in_spread,
  input  wire logic [CNT_W-1:0]         n_eff,
  input  wire logic [DATA_W-1:0]        offset_turns,
  output logic                          push,
  output item_t                         push_item,
  input  wire logic                     full
);

  localparam int PROD_W = DATA_W + CNT_W;
  localparam int HI_W   = POS_W - FRAC_W;
  localparam int DIV_W  = CNT_W + 4;

  // pos_hi mod n; pos_hi < n + 16 keeps the quotient under 16
  function automatic logic [CNT_W-1:0] wrap_hi(input logic [HI_W-1:0] hi,
                                               input logic [CNT_W-1:0] n);
    logic [DIV_W-1:0] r;
    logic [DIV_W-1:0] d;
    r = DIV_W'(hi);
    for (int i = 3; i >= 0; i--) begin
      d = DIV_W'(n) << i;
      if (r >= d) begin
        r = r - d;
      end
    end
    return r[CNT_W-1:0];
  endfunction

  logic                     v1;
  logic signed [DATA_W-1:0] a_sample;
  logic signed [DATA_W-1:0] a_gain;
  logic [CNT_W-1:0]         a_n;
  logic [DATA_W-1:0]        a_s;
  logic [PROD_W-1:0]        a_prod;

  logic [DATA_W-1:0]        p;
  logic [DATA_W-1:0]        s_clamp;
  logic [POS_W-1:0]         pos;
  logic [CNT_W-1:0]         pos_wrap;

  assign in_ready = (!v1 || !full) && !hold;
  assign push     = v1 && !full;

  assign p       = in_azimuth - offset_turns;
  assign s_clamp = (in_spread < SPREAD_MIN) ? SPREAD_MIN : in_spread;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_ready) begin
      v1 <= in_valid;
    end else if (push) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_sample <= in_sample;
      a_gain   <= in_gain;
      a_n      <= n_eff;
      a_s      <= s_clamp;
      a_prod   <= PROD_W'(p) * PROD_W'(n_eff);
    end
  end

  // pos = p*n/16 + s, then wrapped onto [0, n) channels
  assign pos      = POS_W'(a_prod[PROD_W-1:4]) + POS_W'(a_s);
  assign pos_wrap = wrap_hi(pos[POS_W-1:FRAC_W], a_n);

  always_comb begin
    push_item.n      = a_n;
    push_item.x0     = {pos_wrap, pos[FRAC_W-1:0]};
    push_item.two_s  = {a_s, 1'b0};
    push_item.sample = a_sample;
    push_item.gain   = a_gain;
  end

endmodule

`default_nettype wire

@@ src/spmp_queue.sv @@
// Short FIFO of classified items between the front and the back.
`default_nettype none

module spmp_queue import spmp_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  item_t       push_item,
  output logic        full,
  input  wire logic   pop,
  output item_t       pop_item,
  output logic        valid
);

  item_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr;
  logic [QUEUE_AW-1:0]  rd_ptr;
  logic [QUEUE_AW:0]    count;

  assign full     = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign valid    = (count != '0);
  assign pop_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

@@ src/spmp_back.sv @@
// Back end: per-channel sequencer, phase divider, sine lookup, gain and saturation.
`default_nettype none

module spmp_back import spmp_pkg::*; #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  input  item_t                   q_item,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [CHAN_W-1:0]       out_channel,
  output logic signed [DATA_W-1:0] out_level,
  output logic                    out_last,
  output logic                    fill_busy
);

  localparam int TB        = SINE_TABLE_BITS;
  localparam int ROM_DEPTH = (1 << (TB - 1)) + 1;
  localparam int ROM_AW    = $clog2(ROM_DEPTH);
  localparam logic [TB-1:0]     HALF     = TB'(1 << (TB - 1));
  localparam logic [ROM_AW-1:0] ROM_LAST = ROM_AW'(ROM_DEPTH - 1);

  // Quarter-wave-folded half sine, Q1.15, built at elaboration
  function automatic logic [ROM_DEPTH*AMP_W-1:0] build_sine();
    logic [ROM_DEPTH*AMP_W-1:0] tab;
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] t;
    logic [63:0] s;
    tab = '0;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      a  = (64'(k) * PI_Q30) >> TB;
      a2 = (a * a) >> 30;
      t  = ONE_Q30 - a2 / 72;
      t  = ONE_Q30 - ((a2 * t) >> 30) / 42;
      t  = ONE_Q30 - ((a2 * t) >> 30) / 20;
      t  = ONE_Q30 - ((a2 * t) >> 30) / 6;
      s  = (a * t) >> 30;
      s  = (s + 64'd16384) >> 15;
      if (s > 64'd32767) begin
        s = 64'd32767;
      end
      tab[k*AMP_W +: AMP_W] = s[AMP_W-1:0];
    end
    return tab;
  endfunction

  localparam logic [ROM_DEPTH*AMP_W-1:0] SINE_INIT = build_sine();

  typedef struct packed {
    logic [CNT_W-1:0]         j;
    logic                     last;
    logic                     hit;     // x falls inside the lobe
    logic [X_W-1:0]           two_s;
    logic signed [DATA_W-1:0] sample;
    logic signed [DATA_W-1:0] gain;
  } chan_t;

  logic en;   // whole back pipeline advances together

  // ---------------- sine table load after reset ----------------
  logic [ROM_AW-1:0] fill_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_addr <= '0;
      fill_busy <= 1'b1;
    end else if (fill_busy) begin
      fill_addr <= fill_addr + 1'b1;
      if (fill_addr == ROM_LAST) begin
        fill_busy <= 1'b0;
      end
    end
  end

  // ---------------- channel sequencer ----------------
  logic             cur_v;
  item_t            cur_item;
  logic [X_W-1:0]   cur_x;
  logic [CNT_W-1:0] cur_j;
  logic             cur_last;
  logic             take;
  logic [X_W-1:0]   x_dec;
  logic [X_W-1:0]   x_step;

  assign en       = !out_valid || out_ready;
  assign cur_last = (cur_j == cur_item.n - 1'b1);
  assign take     = en && (!cur_v || cur_last);
  assign q_pop    = take && q_valid;

  // next channel sits one step lower on the circle
  assign x_dec  = cur_x - X_ONE;
  assign x_step = (cur_x < X_ONE) ? x_dec + {cur_item.n, {FRAC_W{1'b0}}} : x_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_v <= 1'b0;
    end else if (take) begin
      cur_v <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!cur_v || cur_last) begin
        cur_item <= q_item;
        cur_x    <= q_item.x0;
        cur_j    <= '0;
      end else begin
        cur_x <= x_step;
        cur_j <= cur_j + 1'b1;
      end
    end
  end

  // ---------------- phase divider, one quotient bit per stage ----------------
  logic           dv_v   [TB+1];
  logic [X_W-1:0] dv_rem [TB+1];
  logic [TB-1:0]  dv_q   [TB+1];
  chan_t          dv_c   [TB+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= cur_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem[0]      <= cur_x;
      dv_q[0]        <= '0;
      dv_c[0].j      <= cur_j;
      dv_c[0].last   <= cur_last;
      dv_c[0].hit    <= (cur_x < cur_item.two_s);
      dv_c[0].two_s  <= cur_item.two_s;
      dv_c[0].sample <= cur_item.sample;
      dv_c[0].gain   <= cur_item.gain;
    end
  end

  for (genvar i = 0; i < TB; i++) begin : g_div
    logic [X_W:0] dbl;
    logic         ge;

    assign dbl = {dv_rem[i], 1'b0};
    assign ge  = (dbl >= {1'b0, dv_c[i].two_s});

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[i+1] <= 1'b0;
      end else if (en) begin
        dv_v[i+1] <= dv_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem[i+1] <= ge ? X_W'(dbl - {1'b0, dv_c[i].two_s}) : X_W'(dbl);
        dv_q[i+1]   <= {dv_q[i][TB-2:0], ge};
        dv_c[i+1]   <= dv_c[i];
      end
    end
  end

  // ---------------- sine lookup ----------------
  logic [ROM_AW-1:0] rd_addr;
  logic [AMP_W-1:0]  rom_data;
  logic              rm_v;
  chan_t             rm_c;

  // fold the second quarter back onto the first
  assign rd_addr = (dv_q[TB] > HALF) ? ROM_AW'(-dv_q[TB]) : ROM_AW'(dv_q[TB]);

  spmp_ram #(
    .WIDTH (AMP_W),
    .DEPTH (ROM_DEPTH)
  ) u_sine (
    .clk   (clk),
    .we    (fill_busy),
    .waddr (fill_addr),
    .wdata (SINE_INIT[fill_addr*AMP_W +: AMP_W]),
    .re    (en),
    .raddr (rd_addr),
    .rdata (rom_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rm_v <= 1'b0;
    end else if (en) begin
      rm_v <= dv_v[TB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rm_c <= dv_c[TB];
    end
  end

  // ---------------- scaling ----------------
  logic [AMP_W-1:0]          amp_sel;
  logic                      m1_v;
  logic signed [PROD1_W-1:0] m1_prod;
  logic signed [DATA_W-1:0]  m1_gain;
  logic [CNT_W-1:0]          m1_j;
  logic                      m1_last;
  logic                      m2_v;
  logic signed [PROD2_W-1:0] m2_prod;
  logic [CNT_W-1:0]          m2_j;
  logic                      m2_last;
  logic signed [PROD2_W-1:0] rnd;
  logic signed [SCALED_W-1:0] scaled;
  logic signed [DATA_W-1:0]  level_sat;

  assign amp_sel = rm_c.hit ? rom_data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
      m2_v <= 1'b0;
    end else if (en) begin
      m1_v <= rm_v;
      m2_v <= m1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_prod <= PROD1_W'(rm_c.sample) * PROD1_W'($signed({1'b0, amp_sel}));
      m1_gain <= rm_c.gain;
      m1_j    <= rm_c.j;
      m1_last <= rm_c.last;
      m2_prod <= PROD2_W'(m1_prod) * PROD2_W'(m1_gain);
      m2_j    <= m1_j;
      m2_last <= m1_last;
    end
  end

  // round half up at bit 29, then clamp to Q1.15
  assign rnd    = m2_prod + (PROD2_W'(1) << (ROUND_SHIFT - 1));
  assign scaled = rnd[PROD2_W-1:ROUND_SHIFT];

  always_comb begin
    if (scaled > LEVEL_MAX) begin
      level_sat = LEVEL_MAX[DATA_W-1:0];
    end else if (scaled < LEVEL_MIN) begin
      level_sat = LEVEL_MIN[DATA_W-1:0];
    end else begin
      level_sat = scaled[DATA_W-1:0];
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= m2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_channel <= m2_j[CHAN_W-1:0];
      out_level   <= level_sat;
      out_last    <= m2_last;
    end
  end

endmodule

`default_nettype wire
